>>> sv/fpa_pkg.sv
// Shared types and constants of the fixed-point ALU.
// No dependencies; every other file of the block depends on this package.
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W = 32;
  localparam int ACT_W = 2;
  localparam int PROD_W = 2 * DATA_W;
  // numerator magnitude after the fraction shift, one quotient bit per divider stage
  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam int DIV_STAGES = NUM_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  // everything that rides alongside the divider datapath
  typedef struct packed {
    action_t           action;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              neg;
    logic              dz;
    logic [DATA_W-1:0] alt;
  } fpa_side_t;

endpackage

>>> sv/fpa_in_if.sv
// Request channel of the fixed-point ALU: valid/ready plus operation and operands.
// Depends on fpa_pkg for the field widths.
interface fpa_in_if;
  logic                                valid;
  logic                                ready;
  logic [fpa_pkg::ACT_W-1:0]           action;
  logic signed [fpa_pkg::DATA_W-1:0]   operand_a;
  logic signed [fpa_pkg::DATA_W-1:0]   operand_b;

  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

>>> sv/fpa_out_if.sv
// Result channel of the fixed-point ALU: valid/ready plus result word and flags.
// Depends on fpa_pkg for the field widths.
interface fpa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [fpa_pkg::DATA_W-1:0] result_value;
  logic                              a_less;
  logic                              a_equal;
  logic                              a_greater;
  logic                              divide_by_zero;

  modport source (output valid, result_value, a_less, a_equal, a_greater, divide_by_zero,
                  input ready);
  modport sink   (input valid, result_value, a_less, a_equal, a_greater, divide_by_zero,
                  output ready);
endinterface

>>> sv/fixed_point_alu.sv
// Signed 32-bit fixed-point ALU (FRAC_BITS fraction bits): add, subtract, multiply
// and divide, plus less/equal/greater flags of a against b. The block takes one
// request every cycle while the output is not stalled and returns results in order
// through one input stage holding the 32x32 product and operand magnitudes, NUM_W
// restoring-divider stages that each settle one quotient bit, and
// the output register. The divider pipeline sets the latency; every operation runs
// through it so that order is kept. A stalled output holds the whole pipeline.
// Divide by zero returns 0 with divide_by_zero set; all other overflow wraps.
// Depends on fpa_pkg, fpa_in_if and fpa_out_if.
module fixed_point_alu (
  input  logic        clk,
  input  logic        rst_n,
  fpa_in_if.sink      in_ch,
  fpa_out_if.source   out_ch
);
  import fpa_pkg::*;

  logic adv;

  // input stage
  logic                     s0_valid_r;
  fpa_side_t                s0_side_r, s0_side_nxt;
  logic signed [PROD_W-1:0] s0_prod_r, s0_prod_nxt;
  logic [NUM_W-1:0]         s0_nq_r, s0_nq_nxt;
  logic [DATA_W-1:0]        s0_den_r, s0_den_nxt;

  logic signed [DATA_W-1:0] op_a, op_b;
  logic [DATA_W-1:0]        abs_a;
  action_t                  act;

  // divider stages
  logic              dv_valid_r [DIV_STAGES];
  fpa_side_t         dv_side_r  [DIV_STAGES];
  logic [DATA_W-1:0] dv_rem_r   [DIV_STAGES];
  logic [NUM_W-1:0]  dv_nq_r    [DIV_STAGES];
  logic [DATA_W-1:0] dv_den_r   [DIV_STAGES];

  // output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_result_r, out_result_nxt;
  logic              out_lt_r, out_eq_r, out_gt_r, out_dz_r;
  fpa_side_t         last_side;
  logic [DATA_W-1:0] last_q;

  // advance everything when the output slot is free or being drained
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  assign op_a = in_ch.operand_a;
  assign op_b = in_ch.operand_b;
  assign act  = action_t'(in_ch.action);

  always_comb begin
    abs_a                = op_a[DATA_W-1] ? DATA_W'(-op_a) : op_a;
    s0_side_nxt.action   = act;
    s0_side_nxt.lt       = op_a < op_b;
    s0_side_nxt.eq       = op_a == op_b;
    s0_side_nxt.gt       = op_a > op_b;
    s0_side_nxt.neg      = op_a[DATA_W-1] ^ op_b[DATA_W-1];
    s0_side_nxt.dz       = (act == ACT_DIV) && (op_b == '0);
    case (act)
      ACT_SUB: s0_side_nxt.alt = op_a - op_b;
      default: s0_side_nxt.alt = op_a + op_b;
    endcase
    s0_prod_nxt = op_a * op_b;
    s0_nq_nxt   = NUM_W'(abs_a) << FRAC_BITS;
    s0_den_nxt  = op_b[DATA_W-1] ? DATA_W'(-op_b) : op_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_side_r <= s0_side_nxt;
      s0_prod_r <= s0_prod_nxt;
      s0_nq_r   <= s0_nq_nxt;
      s0_den_r  <= s0_den_nxt;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic              vld_in;
    fpa_side_t         side_in;
    logic [DATA_W-1:0] rem_in, den_in;
    logic [NUM_W-1:0]  nq_in;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   shifted;
    logic              qbit;
    logic [DATA_W-1:0] rem_nxt;
    logic [NUM_W-1:0]  nq_nxt;

    if (k == 0) begin : g_first
      logic signed [PROD_W-1:0] prod_sh;
      assign prod_sh = s0_prod_r >>> FRAC_BITS;
      always_comb begin
        side_in = s0_side_r;
        case (s0_side_r.action)
          ACT_MUL: side_in.alt = prod_sh[DATA_W-1:0];
          default: side_in.alt = s0_side_r.alt;
        endcase
      end
      assign vld_in = s0_valid_r;
      assign rem_in = '0;
      assign nq_in  = s0_nq_r;
      assign den_in = s0_den_r;
    end else begin : g_next
      assign vld_in  = dv_valid_r[k-1];
      assign side_in = dv_side_r[k-1];
      assign rem_in  = dv_rem_r[k-1];
      assign nq_in   = dv_nq_r[k-1];
      assign den_in  = dv_den_r[k-1];
    end

    // bring down the next numerator bit and try one subtract
    assign shifted = {rem_in, nq_in[NUM_W-1]};
    assign trial   = shifted - {1'b0, den_in};
    assign qbit    = !trial[DATA_W];
    assign rem_nxt = qbit ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
    assign nq_nxt  = {nq_in[NUM_W-2:0], qbit};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[k] <= 1'b0;
      end else if (adv) begin
        dv_valid_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side_r[k] <= side_in;
        dv_rem_r[k]  <= rem_nxt;
        dv_nq_r[k]   <= nq_nxt;
        dv_den_r[k]  <= den_in;
      end
    end
  end

  assign last_side = dv_side_r[DIV_STAGES-1];
  assign last_q    = dv_nq_r[DIV_STAGES-1][DATA_W-1:0];

  always_comb begin
    case (last_side.action)
      ACT_DIV: begin
        if (last_side.dz) begin
          out_result_nxt = '0;
        end else if (last_side.neg) begin
          out_result_nxt = -last_q;
        end else begin
          out_result_nxt = last_q;
        end
      end
      default: out_result_nxt = last_side.alt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result_r <= out_result_nxt;
      out_lt_r     <= last_side.lt;
      out_eq_r     <= last_side.eq;
      out_gt_r     <= last_side.gt;
      out_dz_r     <= last_side.dz;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_value   = out_result_r;
  assign out_ch.a_less         = out_lt_r;
  assign out_ch.a_equal        = out_eq_r;
  assign out_ch.a_greater      = out_gt_r;
  assign out_ch.divide_by_zero = out_dz_r;

endmodule

>>> sv/fpa_checker.sv
// Port-level checks of the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg and on the ports of fixed_point_alu.
module fpa_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [fpa_pkg::DATA_W-1:0] out_result,
  input logic                      out_lt,
  input logic                      out_eq,
  input logic                      out_gt,
  input logic                      out_dz
);
  import fpa_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result changed while stalled");

  // exactly one ordering flag per result
  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_lt, out_eq, out_gt}))
    else $error("comparison flags not one-hot");

  // divide by zero gives a zero word
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dz |-> out_result == '0)
    else $error("divide by zero with nonzero result");

  // nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_result (out_ch.result_value),
  .out_lt     (out_ch.a_less),
  .out_eq     (out_ch.a_equal),
  .out_gt     (out_ch.a_greater),
  .out_dz     (out_ch.divide_by_zero)
);
